[sv/skt_pkg.sv]
package skt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int DATA_WIDTH_DEF  = 32;

    localparam int KEY_W   = 5;
    localparam int CODE_W  = 17;
    localparam int POS_W   = 6;
    localparam int CNT_W   = 7;
    localparam int REC_W   = 32;

    localparam logic [KEY_W-1:0] KEY_MAX   = 5'd24;
    localparam int unsigned      CODE_STEP = 1000;
    localparam int unsigned      CODE_BASE = 10000;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]  hour;
        logic [CODE_W-1:0] code;
        logic              pickup;
    } t_entry;

    typedef struct packed {
        logic take_new;
        logic take_left;
        logic take_right;
    } t_cell_ctrl;

    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } t_cell_flags;

endpackage

[sv/skt_cell.sv]
module skt_cell
    import skt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_valid,
    input  logic [KEY_W-1:0]      i_key,
    input  t_cell_ctrl            i_ctrl,
    input  t_entry                i_new,
    input  logic [DATA_WIDTH-1:0] i_new_data,
    input  t_entry                i_left,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  t_entry                i_right,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    output t_entry                o_entry,
    output logic [DATA_WIDTH-1:0] o_data,
    output t_cell_flags           o_flags
);

    t_entry                r_entry;
    logic [DATA_WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.take_new) begin
            r_entry <= i_new;
            r_data  <= i_new_data;
        end else if (i_ctrl.take_left) begin
            r_entry <= i_left;
            r_data  <= i_left_data;
        end else if (i_ctrl.take_right) begin
            r_entry <= i_right;
            r_data  <= i_right_data;
        end
    end

    always_comb begin
        o_flags.lt = i_valid && (r_entry.hour < i_key);
        o_flags.eq = i_valid && (r_entry.hour == i_key);
        o_flags.gt = i_valid && (r_entry.hour > i_key);
    end

    assign o_entry = r_entry;
    assign o_data  = r_data;

endmodule

[sv/sorted_key_table.sv]
// Sorted key table: up to TABLE_DEPTH records held in ascending hour order
// in a row of cells. Input stream (s side): tuser carries the opcode
// (insert, search, delete, no-op), tdata the key, pickup flag and record.
// Output stream (m side): one result item per input item, tuser the status,
// tdata the reported entry and the entry count after the operation.
// Every cell compares its key with the item key in the same cycle; insert
// shifts the cells above the slot one place up, delete shifts the cells
// above the removed entry one place down.
// The result is registered and appears in the cycle after the item is
// accepted. Throughput: one item per cycle while results are taken.
// A waiting result blocks s_tready only when m_tready is low, so a stalled
// receiver holds the table and the result unchanged.
// Reset clears the entry count and the output valid flag; cell contents
// are not cleared, as only entries below the count are ever read.
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [4:0] key_hour, [5] pickup_flag, [37:6] record_data
    input  logic [39:0] i_s_tdata,
    // [1:0] opcode
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [5:0] position, [10:6] found_hour, [27:11] found_code,
    // [28] found_pickup, [60:29] found_data, [67:61] entry_count
    output logic [71:0] o_m_tdata,
    // [1:0] status
    output logic [1:0]  o_m_tuser
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_entry                w_entry [TABLE_DEPTH];
    logic [DATA_WIDTH-1:0] w_data  [TABLE_DEPTH];
    t_cell_flags           w_flags [TABLE_DEPTH];
    t_cell_ctrl            w_ctrl  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_valid, w_slot, w_hit;

    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid;
    t_status       r_status, n_status;
    logic [POS_W-1:0]  r_pos, n_pos;
    t_entry            r_rep, n_rep;
    logic [REC_W-1:0]  r_rep_data, n_rep_data;
    logic [CNT_W-1:0]  r_cnt_out, n_cnt_out;

    t_op               w_op;
    logic [KEY_W-1:0]  w_key;
    logic [REC_W-1:0]  w_rec;
    logic [DATA_WIDTH-1:0] w_new_data;
    t_entry            w_new;
    logic              w_accept, w_full, w_bad, w_found, w_ins_go, w_del_go;
    logic [IW-1:0]     w_slot_idx, w_hit_idx;
    t_entry            w_hit_entry;
    logic [DATA_WIDTH-1:0] w_hit_data;

    assign w_op       = t_op'(i_s_tuser);
    assign w_key      = i_s_tdata[4:0];
    assign w_rec      = i_s_tdata[37:6];
    assign w_new_data = DATA_WIDTH'({32'd0, w_rec});
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count >= CW'(TABLE_DEPTH));
    assign w_bad      = (w_key > KEY_MAX);

    always_comb begin
        w_new.hour   = w_key;
        w_new.code   = CODE_W'(CODE_BASE + 32'(r_count) * CODE_STEP);
        w_new.pickup = i_s_tdata[5];
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            t_entry                w_l, w_r;
            logic [DATA_WIDTH-1:0] w_ld, w_rd;
            if (g == 0) begin : g_first
                assign w_l  = w_new;
                assign w_ld = w_new_data;
            end else begin : g_mid_l
                assign w_l  = w_entry[g-1];
                assign w_ld = w_data[g-1];
            end
            if (g == TABLE_DEPTH - 1) begin : g_last
                assign w_r  = w_entry[g];
                assign w_rd = w_data[g];
            end else begin : g_mid_r
                assign w_r  = w_entry[g+1];
                assign w_rd = w_data[g+1];
            end
            skt_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_valid      (w_valid[g]),
                .i_key        (w_key),
                .i_ctrl       (w_ctrl[g]),
                .i_new        (w_new),
                .i_new_data   (w_new_data),
                .i_left       (w_l),
                .i_left_data  (w_ld),
                .i_right      (w_r),
                .i_right_data (w_rd),
                .o_entry      (w_entry[g]),
                .o_data       (w_data[g]),
                .o_flags      (w_flags[g])
            );
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_valid[i] = (CW'(i) < r_count);
            if (i == 0) begin
                w_slot[i] = !(w_flags[i].lt || w_flags[i].eq);
                w_hit[i]  = w_flags[i].eq;
            end else begin
                w_slot[i] = !(w_flags[i].lt || w_flags[i].eq)
                            && (w_flags[i-1].lt || w_flags[i-1].eq);
                w_hit[i]  = w_flags[i].eq && !w_flags[i-1].eq;
            end
        end
    end

    assign w_found  = |w_hit;
    assign w_ins_go = w_accept && (w_op == OP_INSERT) && !w_full && !w_bad;
    assign w_del_go = w_accept && (w_op == OP_DELETE) && !w_bad && w_found;

    always_comb begin
        w_slot_idx  = '0;
        w_hit_idx   = '0;
        w_hit_entry = '0;
        w_hit_data  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_ctrl[i].take_new   = w_ins_go && w_slot[i];
            w_ctrl[i].take_left  = (i > 0) ? (w_ins_go && w_flags[i-1].gt) : 1'b0;
            w_ctrl[i].take_right = (i < TABLE_DEPTH - 1)
                                   ? (w_del_go && (w_flags[i].eq || w_flags[i].gt)
                                      && w_valid[i+1])
                                   : 1'b0;
            if (w_slot[i]) begin
                w_slot_idx = w_slot_idx | IW'(i);
            end
            if (w_hit[i]) begin
                w_hit_idx   = w_hit_idx | IW'(i);
                w_hit_entry = w_hit_entry | w_entry[i];
                w_hit_data  = w_hit_data | w_data[i];
            end
        end
    end

    always_comb begin
        n_count    = r_count;
        n_status   = ST_OK;
        n_pos      = '0;
        n_rep      = '0;
        n_rep_data = '0;
        if (w_ins_go) begin
            n_count = r_count + 1'b1;
        end else if (w_del_go) begin
            n_count = r_count - 1'b1;
        end
        if (w_op == OP_NOP) begin
            n_status = ST_OK;
        end else if (w_op == OP_INSERT && w_full) begin
            n_status = ST_FULL;
        end else if (w_bad) begin
            n_status = ST_RANGE;
        end else if (w_op == OP_INSERT) begin
            n_pos      = POS_W'(w_slot_idx);
            n_rep      = w_new;
            n_rep_data = w_rec & REC_W'({64'd0, {DATA_WIDTH{1'b1}}});
        end else if (!w_found) begin
            n_status = ST_NOT_FOUND;
        end else begin
            n_pos      = POS_W'(w_hit_idx);
            n_rep      = w_hit_entry;
            n_rep_data = REC_W'({64'd0, w_hit_data});
        end
        n_cnt_out = CNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_status   <= n_status;
            r_pos      <= n_pos;
            r_rep      <= n_rep;
            r_rep_data <= n_rep_data;
            r_cnt_out  <= n_cnt_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {4'd0, r_cnt_out, r_rep_data, r_rep.pickup, r_rep.code,
                         r_rep.hour, r_pos};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_go |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not raise entry count");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_pos == '0 && r_rep == '0))
        else $error("failed operation reports an entry");

    a_delete_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_del_go |-> (r_count != '0 && $onehot(w_hit)))
        else $error("delete without a single first match");

endmodule

[tb/sv/sorted_key_table_tb.sv]
`timescale 1ns / 100ps

module sorted_key_table_tb;
    import skt_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [POS_W-1:0]  position;
        logic [KEY_W-1:0]  hour;
        logic [CODE_W-1:0] code;
        logic              pickup;
        logic [REC_W-1:0]  data;
        logic [CNT_W-1:0]  count;
    } table_report_t;

    class key_table_scoreboard;
        int                errors;
        table_report_t     pending_reports[$];
        logic [KEY_W-1:0]  hours [TABLE_DEPTH_DEF];
        logic [CODE_W-1:0] codes [TABLE_DEPTH_DEF];
        logic              picks [TABLE_DEPTH_DEF];
        logic [REC_W-1:0]  recs  [TABLE_DEPTH_DEF];
        int                fill;

        function new();
            errors = 0;
            fill   = 0;
        endfunction

        function void report_slot(ref table_report_t r, input int slot);
            r.position = POS_W'(slot);
            r.hour     = hours[slot];
            r.code     = codes[slot];
            r.pickup   = picks[slot];
            r.data     = recs[slot];
        endfunction

        function table_report_t apply_table_op(t_op op, logic [KEY_W-1:0] key,
                                               logic pick, logic [REC_W-1:0] data);
            table_report_t r;
            int            i;
            int            slot;
            int unsigned   code_val;
            r = '0;
            r.status = ST_OK;
            slot = -1;
            if (op == OP_NOP) begin
            end else if (op == OP_INSERT && fill >= TABLE_DEPTH_DEF) begin
                r.status = ST_FULL;
            end else if (key > KEY_MAX) begin
                r.status = ST_RANGE;
            end else if (op == OP_INSERT) begin
                i = fill;
                while (i > 0 && hours[i-1] > key) begin
                    hours[i] = hours[i-1];
                    codes[i] = codes[i-1];
                    picks[i] = picks[i-1];
                    recs[i]  = recs[i-1];
                    i--;
                end
                code_val = fill * CODE_STEP + CODE_BASE;
                hours[i] = key;
                codes[i] = code_val[CODE_W-1:0];
                picks[i] = pick;
                recs[i]  = data;
                fill++;
                report_slot(r, i);
            end else begin
                for (i = 0; i < fill; i++) begin
                    if (slot < 0 && hours[i] == key)
                        slot = i;
                end
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    report_slot(r, slot);
                    if (op == OP_DELETE) begin
                        for (i = slot; i + 1 < fill; i++) begin
                            hours[i] = hours[i+1];
                            codes[i] = codes[i+1];
                            picks[i] = picks[i+1];
                            recs[i]  = recs[i+1];
                        end
                        fill--;
                    end
                end
            end
            r.count = CNT_W'(fill);
            return r;
        endfunction

        function void note_item(t_op op, logic [KEY_W-1:0] key, logic pick,
                                logic [REC_W-1:0] data);
            pending_reports.push_back(apply_table_op(op, key, pick, data));
        endfunction

        function void field_check(string name, longint unsigned exp_v,
                                  longint unsigned act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_item(logic [1:0] st, logic [71:0] d);
            table_report_t exp_r;
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %0h data %0h",
                         $time, st, d);
                return;
            end
            exp_r = pending_reports.pop_front();
            field_check("status",       exp_r.status,   st);
            field_check("position",     exp_r.position, d[5:0]);
            field_check("found_hour",   exp_r.hour,     d[10:6]);
            field_check("found_code",   exp_r.code,     d[27:11]);
            field_check("found_pickup", exp_r.pickup,   d[28]);
            field_check("found_data",   exp_r.data,     d[60:29]);
            field_check("entry_count",  exp_r.count,    d[67:61]);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // [4:0] key_hour, [5] pickup_flag, [37:6] record_data
    logic [39:0] i_s_tdata  = '0;
    // [1:0] opcode
    logic [1:0]  i_s_tuser  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // [5:0] position, [10:6] found_hour, [27:11] found_code,
    // [28] found_pickup, [60:29] found_data, [67:61] entry_count
    logic [71:0] o_m_tdata;
    // [1:0] status
    logic [1:0]  o_m_tuser;

    key_table_scoreboard sb;
    bit                  no_idle = 1'b0;
    int                  stall_left = 0;

    sorted_key_table DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver back-pressure
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_left == 0 && !no_idle && $urandom_range(0, 3) == 0)
                stall_left = idle_len();
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_item(o_m_tuser, o_m_tdata);
    end

    task automatic push_item(input t_op op, input logic [KEY_W-1:0] key,
                             input logic pick, input logic [REC_W-1:0] data);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, data, pick, key};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(op, key, pick, data);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(bit narrow);
        if ($urandom_range(0, 9) == 0)
            return KEY_W'($urandom_range(25, 31));
        if (narrow)
            return KEY_W'($urandom_range(0, 3));
        return KEY_W'($urandom_range(0, 24));
    endfunction

    initial begin
        int   sent;
        int   phase_len;
        int   kind;
        int   r;
        bit   narrow;
        t_op  op;

        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, out-of-range keys, duplicates, no-op
        push_item(OP_SEARCH, 5'd5,  1'b0, 32'h0000_0000);
        push_item(OP_DELETE, 5'd5,  1'b0, 32'h0000_0000);
        push_item(OP_NOP,    5'd0,  1'b0, 32'h0000_0000);
        push_item(OP_INSERT, 5'd31, 1'b1, 32'hFFFF_FFFF);
        push_item(OP_INSERT, 5'd12, 1'b1, 32'hFFFF_FFFF);
        push_item(OP_INSERT, 5'd0,  1'b0, 32'h0000_0000);
        push_item(OP_INSERT, 5'd24, 1'b1, 32'hA5A5_5A5A);
        push_item(OP_INSERT, 5'd12, 1'b0, 32'h0000_1234);
        push_item(OP_INSERT, 5'd25, 1'b0, 32'h8000_0001);
        push_item(OP_SEARCH, 5'd12, 1'b0, 32'h0000_0000);
        push_item(OP_SEARCH, 5'd24, 1'b1, 32'hFFFF_FFFF);
        push_item(OP_SEARCH, 5'd0,  1'b0, 32'h0000_0000);
        push_item(OP_SEARCH, 5'd7,  1'b0, 32'h0000_0000);
        push_item(OP_SEARCH, 5'd31, 1'b0, 32'h0000_0000);
        push_item(OP_DELETE, 5'd31, 1'b0, 32'h0000_0000);
        push_item(OP_DELETE, 5'd12, 1'b0, 32'h0000_0000);
        push_item(OP_SEARCH, 5'd12, 1'b0, 32'h0000_0000);
        push_item(OP_DELETE, 5'd0,  1'b0, 32'h0000_0000);
        push_item(OP_DELETE, 5'd24, 1'b0, 32'h0000_0000);
        push_item(OP_DELETE, 5'd12, 1'b0, 32'h0000_0000);
        push_item(OP_DELETE, 5'd12, 1'b0, 32'h0000_0000);
        push_item(OP_NOP,    5'd31, 1'b1, 32'hFFFF_FFFF);

        // random phases: filling, draining, mixed
        sent = 0;
        while (sent < 1150) begin
            kind      = $urandom_range(0, 2);
            narrow    = ($urandom_range(0, 3) == 0);
            no_idle   = ($urandom_range(0, 4) == 0);
            phase_len = (kind == 0) ? $urandom_range(80, 160) : $urandom_range(40, 120);
            repeat (phase_len) begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    op = OP_NOP;
                else if (kind == 0)
                    op = (r < 77) ? OP_INSERT : (r < 92) ? OP_SEARCH : OP_DELETE;
                else if (kind == 1)
                    op = (r < 72) ? OP_DELETE : (r < 87) ? OP_INSERT : OP_SEARCH;
                else
                    op = (r < 35) ? OP_INSERT : (r < 68) ? OP_SEARCH : OP_DELETE;
                push_item(op, pick_key(narrow), 1'($urandom), $urandom);
                sent++;
            end
        end
        no_idle = 1'b0;

        i_s_tvalid <= 1'b0;
        while (sb.pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_reports.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
